// ===== src/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Voices asked for, and voices built: the result fields are 16 voices wide.
  localparam int Voices    = 16;
  localparam int MaskW     = 16;
  localparam int NVoice    = (Voices < MaskW) ? Voices : MaskW;
  localparam int KeyW      = 7;
  localparam int CmdW      = 2;
  localparam int VoiceIdxW = 4;

  // The last code is not assigned to any command and leaves the voices alone.
  typedef enum logic [CmdW-1:0] {
    CmdNoteOn  = 2'd0,
    CmdNoteOff = 2'd1,
    CmdUpdate  = 2'd2,
    CmdUnused  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [KeyW-1:0]  key;
    logic [MaskW-1:0] env_off_mask;
  } item_t;

  typedef struct packed {
    logic                 status;
    logic [VoiceIdxW-1:0] voice_index;
    logic                 start_attack;
    logic [MaskW-1:0]     active_mask;
    logic [MaskW-1:0]     gate_mask;
  } result_t;

endpackage

// ===== src/pva_if.sv =====
// ----------------------------------------------------------------------------
// pva_in_if / pva_out_if
// Valid/ready channels carrying commands into and results out of the block.
// ----------------------------------------------------------------------------
interface pva_in_if;
  logic                     valid;
  logic                     ready;
  logic [pva_pkg::CmdW-1:0]  command;
  logic [pva_pkg::KeyW-1:0]  key;
  logic [pva_pkg::MaskW-1:0] env_off_mask;

  modport source (output valid, command, key, env_off_mask, input ready);
  modport sink   (input valid, command, key, env_off_mask, output ready);
endinterface

interface pva_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [pva_pkg::VoiceIdxW-1:0] voice_index;
  logic                         start_attack;
  logic [pva_pkg::MaskW-1:0]     active_mask;
  logic [pva_pkg::MaskW-1:0]     gate_mask;

  modport source (output valid, status, voice_index, start_attack, active_mask,
                  gate_mask, input ready);
  modport sink   (input valid, status, voice_index, start_attack, active_mask,
                  gate_mask, output ready);
endinterface

// ===== src/pva_core.sv =====
// ----------------------------------------------------------------------------
// pva_core
// Voice state registers, voice selection and the per-command state update.
// ----------------------------------------------------------------------------
module pva_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pva_pkg::item_t   item_i,
  output pva_pkg::result_t result_o
);
  import pva_pkg::*;

  logic [NVoice-1:0] on_q, on_d;
  logic [NVoice-1:0] gate_q, gate_d;
  logic [KeyW-1:0]   note_q [NVoice];
  logic [KeyW-1:0]   note_d [NVoice];

  logic [NVoice-1:0] free_mask, rel_mask, pick_src, pick_oh, key_hit, clr_mask;
  logic [VoiceIdxW-1:0] pick_idx;
  logic              found;

  always_comb begin
    free_mask = ~on_q;
    rel_mask  = on_q & ~gate_q;
    pick_src  = (|free_mask) ? free_mask : rel_mask;
    found     = |pick_src;
    // Isolate the lowest set bit.
    pick_oh   = pick_src & (~pick_src + NVoice'(1));
    pick_idx  = '0;
    for (int v = 0; v < NVoice; v++) begin
      if (pick_oh[v]) begin
        pick_idx = VoiceIdxW'(v);
      end
      key_hit[v] = on_q[v] && (note_q[v] == item_i.key);
    end
    clr_mask = on_q & item_i.env_off_mask[NVoice-1:0];
  end

  always_comb begin
    on_d     = on_q;
    gate_d   = gate_q;
    note_d   = note_q;
    result_o = '0;
    case (cmd_e'(item_i.command))
      CmdNoteOn: begin
        if (found) begin
          on_d   = on_q | pick_oh;
          gate_d = gate_q | pick_oh;
          for (int v = 0; v < NVoice; v++) begin
            if (pick_oh[v]) begin
              note_d[v] = item_i.key;
            end
          end
          result_o.voice_index  = pick_idx;
          result_o.start_attack = 1'b1;
        end else begin
          result_o.status = 1'b1;
        end
      end
      CmdNoteOff: begin
        gate_d = gate_q & ~key_hit;
      end
      CmdUpdate: begin
        on_d   = on_q & ~clr_mask;
        gate_d = gate_q & ~clr_mask;
        for (int v = 0; v < NVoice; v++) begin
          if (clr_mask[v]) begin
            note_d[v] = '0;
          end
        end
      end
      default: begin
      end
    endcase
    result_o.active_mask = MaskW'(on_d);
    result_o.gate_mask   = MaskW'(gate_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q   <= '0;
      gate_q <= '0;
      for (int v = 0; v < NVoice; v++) begin
        note_q[v] <= '0;
      end
    end else if (step_i) begin
      on_q   <= on_d;
      gate_q <= gate_d;
      note_q <= note_d;
    end
  end

endmodule

// ===== src/poly_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// poly_voice_allocator
// Polyphonic voice allocator: note on, note off and envelope status update.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload
//   in_i     in   command, key, env_off_mask
//   out_o    out  status, voice_index, start_attack, active_mask, gate_mask
//
// An item is registered on accept and its result is registered as the item
// advances; one item is taken every cycle unless the output is stalled.
// The voice state is updated as the item moves into the result register.
// A stalled output holds both stages; the input is still taken while the
// input register is empty. Reset clears all voices and both valid flags.
module poly_voice_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  pva_in_if.sink     in_i,
  pva_out_if.source  out_o
);
  import pva_pkg::*;

  logic    in_vld_q, out_vld_q;
  item_t   item_q;
  result_t res_q, res_d;
  logic    advance;

  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  pva_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.command      <= in_i.command;
      item_q.key          <= in_i.key;
      item_q.env_off_mask <= in_i.env_off_mask;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = res_q.status;
  assign out_o.voice_index  = res_q.voice_index;
  assign out_o.start_attack = res_q.start_attack;
  assign out_o.active_mask  = res_q.active_mask;
  assign out_o.gate_mask    = res_q.gate_mask;

endmodule

// ===== src/pva_checker.sv =====
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to its top level.
// ----------------------------------------------------------------------------
module pva_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          status_i,
  input logic [pva_pkg::VoiceIdxW-1:0] voice_index_i,
  input logic                          start_attack_i,
  input logic [pva_pkg::MaskW-1:0]     active_mask_i,
  input logic [pva_pkg::MaskW-1:0]     gate_mask_i
);
  import pva_pkg::*;

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A failed note-on reports no voice and no attack.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> !start_attack_i && voice_index_i == '0)
    else $error("failed note-on carries a voice");

  // The voice given to a note-on is active and gated afterwards.
  a_pick_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_attack_i |->
      active_mask_i[voice_index_i] && gate_mask_i[voice_index_i])
    else $error("picked voice not active and gated");

  // A gate is never held by an inactive voice.
  a_gate_in_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (gate_mask_i & ~active_mask_i) == '0)
    else $error("gate set on inactive voice");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .voice_index_i  (out_o.voice_index),
  .start_attack_i (out_o.start_attack),
  .active_mask_i  (out_o.active_mask),
  .gate_mask_i    (out_o.gate_mask)
);
